// ===== sv/bsbi_pkg.sv =====
// Shared constants and types of the bounded stack with bottom increment.
package bsbi_pkg;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 16;
    localparam int CAP_W    = 7;

    localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_INC  = 2'd2;

    localparam logic [CAP_W-1:0]          CAP_RESET  = 7'd64;
    localparam logic signed [VALUE_W-1:0] EMPTY_WORD = -32'sd1;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DISP = 5'b00010,
        S_INC  = 5'b00100,
        S_POP  = 5'b01000,
        S_FOLD = 5'b10000
    } t_state;

endpackage

// ===== sv/bsbi_ifs.sv =====
// Handshake channels: request, response and capacity write.
interface bsbi_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [bsbi_pkg::ACTION_W-1:0]         action;
    logic signed [bsbi_pkg::VALUE_W-1:0]   value;
    logic [bsbi_pkg::COUNT_W-1:0]          count;

    modport source (output valid, output action, output value, output count, input ready);
    modport sink   (input valid, input action, input value, input count, output ready);
endinterface

interface bsbi_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [bsbi_pkg::VALUE_W-1:0]   popped_value;
    logic                                  was_empty;

    modport source (output valid, output popped_value, output was_empty, input ready);
    modport sink   (input valid, input popped_value, input was_empty, output ready);
endinterface

interface bsbi_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [bsbi_pkg::CAP_W-1:0]            capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

// ===== sv/bsbi_ram.sv =====
// Single-port-read, single-port-write word memory with registered read data.
module bsbi_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bounded_stack_with_bottom_increment.sv =====
// Top level of the bounded stack with bottom increment: sequencer, shared adder, memories.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+--------------------------------------
//   i_req   | in  | valid / ready | action, value, count
//   o_rsp   | out | valid / ready | popped_value, was_empty (pops only)
//   i_cfg   | in  | valid / ready | capacity (ready always high)
//
// Each request passes IDLE and DISP; an increment that touches entries adds
// S_INC, a pop adds S_POP and then S_FOLD (no S_FOLD when it removes the last
// entry, neither on an empty stack). A pop waits while the response register
// stays full. One adder and the single read port of the increment memory are
// walked through these steps by the sequencer.
// Reset (synchronous, active low) empties the stack, clears the response
// register and sets capacity to 64; memories are not cleared.
//
// Increments are kept lazily: inc[k] holds an amount owed by entries 0..k.
// A pop adds inc[top] to the word and folds it down into inc[top-1].
module bounded_stack_with_bottom_increment #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsbi_req_if.sink    i_req,
    bsbi_rsp_if.source  o_rsp,
    bsbi_cfg_if.sink    i_cfg
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > bsbi_pkg::CAP_W) ? CW : bsbi_pkg::CAP_W;
    localparam int VW   = bsbi_pkg::VALUE_W;

    bsbi_pkg::t_state                  r_state, n_state;
    logic [CW-1:0]                     r_cnt, n_cnt;
    logic [bsbi_pkg::CAP_W-1:0]        r_cap;
    logic [bsbi_pkg::ACTION_W-1:0]     r_act, n_act;
    logic signed [VW-1:0]              r_val, n_val;
    logic [bsbi_pkg::COUNT_W-1:0]      r_count, n_count;
    logic [AW-1:0]                     r_addr, n_addr;
    logic signed [VW-1:0]              r_acc, n_acc;
    logic                              r_out_valid, n_out_valid;
    logic signed [VW-1:0]              r_out_val, n_out_val;
    logic                              r_out_empty, n_out_empty;

    // Memory ports.
    logic          ent_we, ent_re, inc_we, inc_re;
    logic [AW-1:0] ent_waddr, ent_raddr, inc_waddr, inc_raddr;
    logic [VW-1:0] ent_wdata, inc_wdata, ent_rd, inc_rd;

    // Shared adder.
    logic signed [VW-1:0] add_a, add_b, add_sum;

    logic          out_free;
    logic          can_push;
    logic [CW-1:0] inc_n;

    bsbi_ram #(.DEPTH(DEPTH), .DW(VW)) u_entries (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rd)
    );

    bsbi_ram #(.DEPTH(DEPTH), .DW(VW)) u_incs (
        .i_clk   (i_clk),
        .i_we    (inc_we),
        .i_waddr (inc_waddr),
        .i_wdata (inc_wdata),
        .i_re    (inc_re),
        .i_raddr (inc_raddr),
        .o_rdata (inc_rd)
    );

    assign i_req.ready        = (r_state == bsbi_pkg::S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.popped_value = r_out_val;
    assign o_rsp.was_empty    = r_out_empty;

    // Response register may load when empty or drained in this cycle.
    assign out_free = !r_out_valid || o_rsp.ready;

    // Capacity above DEPTH saturates through the second compare.
    assign can_push = (CMPW'(r_cnt) < CMPW'(r_cap)) && (32'(r_cnt) < DEPTH);

    // Clip the increment span to the stored count.
    assign inc_n = (r_count < bsbi_pkg::COUNT_W'(r_cnt)) ? CW'(r_count) : r_cnt;

    // Operand select for the one adder.
    always_comb begin
        add_a = r_acc;
        add_b = r_val;
        case (r_state)
            bsbi_pkg::S_INC: begin
                add_a = inc_rd;
                add_b = r_val;
            end
            bsbi_pkg::S_POP: begin
                add_a = ent_rd;
                add_b = inc_rd;
            end
            bsbi_pkg::S_FOLD: begin
                add_a = inc_rd;
                add_b = r_acc;
            end
            default: begin
                add_a = r_acc;
                add_b = r_val;
            end
        endcase
    end

    assign add_sum = add_a + add_b;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_act       = r_act;
        n_val       = r_val;
        n_count     = r_count;
        n_addr      = r_addr;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        n_out_val   = r_out_val;
        n_out_empty = r_out_empty;
        ent_we      = 1'b0;
        ent_re      = 1'b0;
        inc_we      = 1'b0;
        inc_re      = 1'b0;
        ent_waddr   = '0;
        ent_raddr   = '0;
        inc_waddr   = '0;
        inc_raddr   = '0;
        ent_wdata   = r_val;
        inc_wdata   = '0;

        // Drop the response once taken; a load below overrides.
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bsbi_pkg::S_IDLE: begin
                // Latch the request.
                if (i_req.valid) begin
                    n_act   = i_req.action;
                    n_val   = i_req.value;
                    n_count = i_req.count;
                    n_state = bsbi_pkg::S_DISP;
                end
            end
            bsbi_pkg::S_DISP: begin
                case (r_act)
                    bsbi_pkg::ACT_PUSH: begin
                        // Store word, clear its owed increment; drop when full.
                        if (can_push) begin
                            ent_we    = 1'b1;
                            ent_waddr = AW'(r_cnt);
                            ent_wdata = r_val;
                            inc_we    = 1'b1;
                            inc_waddr = AW'(r_cnt);
                            inc_wdata = '0;
                            n_cnt     = r_cnt + CW'(1);
                        end
                        n_state = bsbi_pkg::S_IDLE;
                    end
                    bsbi_pkg::ACT_POP: begin
                        if (r_cnt == '0) begin
                            if (out_free) begin
                                n_out_valid = 1'b1;
                                n_out_val   = bsbi_pkg::EMPTY_WORD;
                                n_out_empty = 1'b1;
                                n_state     = bsbi_pkg::S_IDLE;
                            end
                        end else begin
                            ent_re    = 1'b1;
                            ent_raddr = AW'(r_cnt - CW'(1));
                            inc_re    = 1'b1;
                            inc_raddr = AW'(r_cnt - CW'(1));
                            n_addr    = AW'(r_cnt - CW'(1));
                            n_cnt     = r_cnt - CW'(1);
                            n_state   = bsbi_pkg::S_POP;
                        end
                    end
                    bsbi_pkg::ACT_INC: begin
                        if (inc_n != '0) begin
                            inc_re    = 1'b1;
                            inc_raddr = AW'(inc_n - CW'(1));
                            n_addr    = AW'(inc_n - CW'(1));
                            n_state   = bsbi_pkg::S_INC;
                        end else begin
                            n_state = bsbi_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        n_state = bsbi_pkg::S_IDLE;
                    end
                endcase
            end
            bsbi_pkg::S_INC: begin
                inc_we    = 1'b1;
                inc_waddr = r_addr;
                inc_wdata = add_sum;
                n_state   = bsbi_pkg::S_IDLE;
            end
            bsbi_pkg::S_POP: begin
                // Hold until the response register is free; read data stays put.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_val   = add_sum;
                    n_out_empty = 1'b0;
                    n_acc       = inc_rd;
                    if (r_addr == '0) begin
                        n_state = bsbi_pkg::S_IDLE;
                    end else begin
                        inc_re    = 1'b1;
                        inc_raddr = r_addr - AW'(1);
                        n_addr    = r_addr - AW'(1);
                        n_state   = bsbi_pkg::S_FOLD;
                    end
                end
            end
            bsbi_pkg::S_FOLD: begin
                // Advance the owed amount to the new top.
                inc_we    = 1'b1;
                inc_waddr = r_addr;
                inc_wdata = add_sum;
                n_state   = bsbi_pkg::S_IDLE;
            end
            default: begin
                n_state = bsbi_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsbi_pkg::S_IDLE;
            r_cnt       <= '0;
            r_cap       <= bsbi_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_cap <= i_cfg.capacity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act       <= n_act;
        r_val       <= n_val;
        r_count     <= n_count;
        r_addr      <= n_addr;
        r_acc       <= n_acc;
        r_out_val   <= n_out_val;
        r_out_empty <= n_out_empty;
    end

endmodule

// ===== sv/bsbi_checker.sv =====
// Port-level checks of the bounded stack, attached by bind.
module bsbi_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_req_valid,
    input logic                              i_req_ready,
    input logic                              i_rsp_valid,
    input logic                              i_rsp_ready,
    input logic signed [bsbi_pkg::VALUE_W-1:0] i_rsp_value,
    input logic                              i_rsp_empty
);

    // A stalled response holds its payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_value) && $stable(i_rsp_empty))
        else $error("response changed while stalled");

    // Reset leaves no response pending.
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // An empty pop always reports all ones.
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_empty |-> i_rsp_value == bsbi_pkg::EMPTY_WORD)
        else $error("empty pop with wrong word");

    // The block is busy in the cycle after taking a request.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

endmodule

bind bounded_stack_with_bottom_increment bsbi_checker u_bsbi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_value (o_rsp.popped_value),
    .i_rsp_empty (o_rsp.was_empty)
);

// ===== verif/tb_bounded_stack_with_bottom_increment.sv =====
// Testbench for the bounded stack with bottom increment: requests checked against a shadow stack.
module tb_bounded_stack_with_bottom_increment;

    localparam int STACK_DEPTH   = 64;
    localparam int CYCLE_LIMIT   = 200000;
    // Longest path between accepted requests is a pop; leave margin.
    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_PERCENT  = 16;
    localparam int HOLD_CYCLES   = 300;
    // The one action code the block ignores.
    localparam logic [bsbi_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;

    typedef struct {
        logic signed [bsbi_pkg::VALUE_W-1:0] popped_value;
        logic                                was_empty;
    } t_pop_result;

    logic clk;
    logic rst_n;

    bsbi_req_if req_if ();
    bsbi_rsp_if rsp_if ();
    bsbi_cfg_if cfg_if ();

    bounded_stack_with_bottom_increment #(
        .DEPTH (STACK_DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the stack contents, fill level and capacity register.
    logic signed [bsbi_pkg::VALUE_W-1:0] shadow_words [STACK_DEPTH];
    int unsigned                         shadow_depth;
    int unsigned                         shadow_capacity;

    // Pop results still owed by the block, oldest first.
    t_pop_result popped_words [$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          rsp_holding = 1'b0;
    bit          steady_flow;
    event        rsp_hold_go;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Bound the run; a hang anywhere ends here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[bounded_stack_with_bottom_increment] ERROR");
            $finish;
        end
    end

    // Count the long response hold-off in cycles.
    initial begin
        forever begin
            @(rsp_hold_go);
            rsp_holding = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            rsp_holding = 1'b0;
        end
    end

    // Random count over the whole field.
    function automatic logic [bsbi_pkg::COUNT_W-1:0] rand_count();
        logic [31:0] r;
        r = $urandom();
        return r[bsbi_pkg::COUNT_W-1:0];
    endfunction

    // Apply one accepted request to the shadow stack; queue the result of a pop.
    function automatic void run_stack_op(input logic [bsbi_pkg::ACTION_W-1:0] action,
                                         input logic signed [bsbi_pkg::VALUE_W-1:0] value,
                                         input logic [bsbi_pkg::COUNT_W-1:0] count);
        int unsigned room;
        int unsigned span;
        t_pop_result res;
        // Capacity above the physical depth saturates at the depth.
        room = (shadow_capacity > STACK_DEPTH) ? STACK_DEPTH : shadow_capacity;
        case (action)
            bsbi_pkg::ACT_PUSH: begin
                // Drop the word when full, including capacity zero or lowered capacity.
                if (shadow_depth < room) begin
                    shadow_words[shadow_depth] = value;
                    shadow_depth++;
                end
            end
            bsbi_pkg::ACT_POP: begin
                if (shadow_depth == 0) begin
                    res.popped_value = bsbi_pkg::EMPTY_WORD;
                    res.was_empty    = 1'b1;
                end else begin
                    shadow_depth--;
                    res.popped_value = shadow_words[shadow_depth];
                    res.was_empty    = 1'b0;
                end
                popped_words.push_back(res);
            end
            bsbi_pkg::ACT_INC: begin
                // Clip the count to the stored words; wrap in two's complement.
                span = (32'(count) < shadow_depth) ? 32'(count) : shadow_depth;
                for (int i = 0; i < span; i++)
                    shadow_words[i] = shadow_words[i] + value;
            end
            default: begin
                // Ignored action: no state change, no result.
            end
        endcase
    endfunction

    // Response side: stall at random, or hold off for a counted stretch.
    always @(negedge clk) begin
        if (!rst_n || rsp_holding) begin
            rsp_if.ready <= 1'b0;
        end else if (steady_flow) begin
            rsp_if.ready <= 1'b1;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Compare every accepted pop result with the oldest one owed.
    always @(posedge clk) begin
        t_pop_result want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (popped_words.size() == 0) begin
                $error("unexpected pop result: popped_value %0d was_empty %0b",
                       rsp_if.popped_value, rsp_if.was_empty);
                error_count++;
            end else begin
                want = popped_words.pop_front();
                if (rsp_if.popped_value !== want.popped_value) begin
                    $error("popped_value: expected %0d, got %0d",
                           want.popped_value, rsp_if.popped_value);
                    error_count++;
                end
                if (rsp_if.was_empty !== want.was_empty) begin
                    $error("was_empty: expected %0b, got %0b",
                           want.was_empty, rsp_if.was_empty);
                    error_count++;
                end
            end
        end
    end

    // Offer one request after a random gap; return once it is accepted.
    task automatic send_request(input logic [bsbi_pkg::ACTION_W-1:0] action,
                                input logic signed [bsbi_pkg::VALUE_W-1:0] value,
                                input logic [bsbi_pkg::COUNT_W-1:0] count);
        @(negedge clk);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            req_if.valid  <= 1'b0;
            req_if.action <= bsbi_pkg::ACTION_W'($urandom());
            req_if.value  <= $urandom();
            req_if.count  <= rand_count();
            @(negedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.action <= action;
        req_if.value  <= value;
        req_if.count  <= count;
        do @(posedge clk); while (!req_if.ready);
        run_stack_op(action, value, count);
    endtask

    // Pick a random request; the split between pushes and pops steers the fill level.
    task automatic send_random_request(input int push_pct, input int pop_pct);
        int                                  roll;
        logic [bsbi_pkg::ACTION_W-1:0]       action;
        logic signed [bsbi_pkg::VALUE_W-1:0] value;
        logic [bsbi_pkg::COUNT_W-1:0]        count;
        roll = $urandom_range(99);
        if (roll < push_pct)
            action = bsbi_pkg::ACT_PUSH;
        else if (roll < push_pct + pop_pct)
            action = bsbi_pkg::ACT_POP;
        else if (roll < 94)
            action = bsbi_pkg::ACT_INC;
        else
            action = ACT_NONE;
        value = $urandom();
        // Mostly counts near the fill level, sometimes anywhere in the field.
        if ($urandom_range(9) < 7)
            count = bsbi_pkg::COUNT_W'($urandom_range(shadow_depth + 2));
        else
            count = rand_count();
        send_request(action, value, count);
    endtask

    // Drop valid, wait for every owed result, then let the block finish its work.
    task automatic wait_until_drained;
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (popped_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the capacity register while the block is idle.
    task automatic write_capacity(input logic [bsbi_pkg::CAP_W-1:0] cap);
        wait_until_drained();
        @(negedge clk);
        cfg_if.valid    <= 1'b1;
        cfg_if.capacity <= cap;
        do @(posedge clk); while (!cfg_if.ready);
        shadow_capacity = 32'(cap);
        @(negedge clk);
        cfg_if.valid    <= 1'b0;
        cfg_if.capacity <= bsbi_pkg::CAP_W'($urandom());
    endtask

    // Empty pop, ignored action and increment on an empty stack, at reset capacity.
    task automatic test_empty_and_ignored;
        send_request(bsbi_pkg::ACT_POP, $urandom(), rand_count());
        send_request(ACT_NONE, $urandom(), rand_count());
        send_request(bsbi_pkg::ACT_INC, 32'sd7, 16'hFFFF);
        send_request(bsbi_pkg::ACT_POP, $urandom(), rand_count());
    endtask

    // Extreme words, wrapping increments, zero and oversized counts.
    task automatic test_field_extremes;
        send_request(bsbi_pkg::ACT_PUSH, 32'sh7FFF_FFFF, 16'h0000);
        send_request(bsbi_pkg::ACT_PUSH, 32'sh8000_0000, 16'hFFFF);
        send_request(bsbi_pkg::ACT_PUSH, 32'sh0000_0000, rand_count());
        send_request(bsbi_pkg::ACT_PUSH, -32'sd1, rand_count());
        send_request(ACT_NONE, $urandom(), rand_count());
        send_request(bsbi_pkg::ACT_INC, 32'sd1, 16'd1);
        send_request(bsbi_pkg::ACT_INC, -32'sd1, 16'hFFFF);
        send_request(bsbi_pkg::ACT_INC, 32'sh8000_0000, 16'd0);
        send_request(bsbi_pkg::ACT_INC, 32'sh8000_0000, 16'd2);
        repeat (5) send_request(bsbi_pkg::ACT_POP, $urandom(), rand_count());
    endtask

    // Capacity one, zero, and lowered below the fill level.
    task automatic test_capacity_limits;
        write_capacity(7'd1);
        send_request(bsbi_pkg::ACT_PUSH, $urandom(), rand_count());
        send_request(bsbi_pkg::ACT_PUSH, $urandom(), rand_count());
        send_request(bsbi_pkg::ACT_POP, $urandom(), rand_count());
        send_request(bsbi_pkg::ACT_POP, $urandom(), rand_count());
        write_capacity(7'd0);
        send_request(bsbi_pkg::ACT_PUSH, $urandom(), rand_count());
        send_request(bsbi_pkg::ACT_POP, $urandom(), rand_count());
        write_capacity(7'd64);
        repeat (3) send_request(bsbi_pkg::ACT_PUSH, $urandom(), rand_count());
        // Keep the three stored words; pushes drop until the fill falls below two.
        write_capacity(7'd2);
        send_request(bsbi_pkg::ACT_PUSH, $urandom(), rand_count());
        send_request(bsbi_pkg::ACT_INC, $urandom(), 16'd2);
        send_request(bsbi_pkg::ACT_POP, $urandom(), rand_count());
        send_request(bsbi_pkg::ACT_POP, $urandom(), rand_count());
        send_request(bsbi_pkg::ACT_PUSH, $urandom(), rand_count());
        repeat (3) send_request(bsbi_pkg::ACT_POP, $urandom(), rand_count());
    endtask

    // Capacity above the depth: fill past the top, increment, drain past empty.
    task automatic test_full_stack;
        write_capacity(7'd127);
        repeat (STACK_DEPTH + 2) send_request(bsbi_pkg::ACT_PUSH, $urandom(), rand_count());
        send_request(bsbi_pkg::ACT_INC, $urandom(),
                     bsbi_pkg::COUNT_W'($urandom_range(STACK_DEPTH, 1)));
        repeat (STACK_DEPTH + 2) send_request(bsbi_pkg::ACT_POP, $urandom(), rand_count());
    endtask

    // Hold off the response side while pops keep coming, so the block stalls.
    task automatic test_response_backpressure;
        write_capacity(7'd64);
        repeat (16) send_request(bsbi_pkg::ACT_PUSH, $urandom(), rand_count());
        -> rsp_hold_go;
        repeat (16) send_request(bsbi_pkg::ACT_POP, $urandom(), rand_count());
    endtask

    // Random phases over several capacities: fill first, then drain.
    task automatic test_random_mix;
        logic [bsbi_pkg::CAP_W-1:0] caps [6];
        caps[0] = 7'd64;
        caps[1] = bsbi_pkg::CAP_W'($urandom_range(127, 1));
        caps[2] = 7'd0;
        caps[3] = 7'd1;
        caps[4] = 7'd127;
        caps[5] = bsbi_pkg::CAP_W'($urandom_range(63, 1));
        for (int p = 0; p < 6; p++) begin
            write_capacity(caps[p]);
            // One phase runs with neither side idling.
            steady_flow = (p == 1);
            repeat (21) send_random_request(55, 25);
            // Pause the sender until every owed result is back.
            if (p == 3)
                wait_until_drained();
            repeat (21) send_random_request(20, 55);
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.action   = bsbi_pkg::ACT_PUSH;
        req_if.value    = '0;
        req_if.count    = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.capacity = '0;
        steady_flow     = 1'b0;
        shadow_depth    = 0;
        shadow_capacity = 32'(bsbi_pkg::CAP_RESET);

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_ignored();
        test_field_extremes();
        test_capacity_limits();
        test_full_stack();
        test_response_backpressure();
        test_random_mix();

        wait_until_drained();
        if (error_count == 0) begin
            $display("[bounded_stack_with_bottom_increment] OK");
        end else begin
            $display("[bounded_stack_with_bottom_increment] ERROR");
        end
        $finish;
    end

endmodule
